// File: hw/rtl/sbm_pkg.sv
// Package for the sprite bounds motion step unit: item codes, edge modes,
// register indexes and register reset values. No dependencies.
`default_nettype none

package sbm_pkg;

	localparam int COORD_BITS_DEF = 16;

	// Item kinds.
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_KILL = 2'd2;

	// Edge actions.
	localparam logic [1:0] MODE_STOP   = 2'd0;
	localparam logic [1:0] MODE_WRAP   = 2'd1;
	localparam logic [1:0] MODE_BOUNCE = 2'd2;
	localparam logic [1:0] MODE_DIE    = 2'd3;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_BOUND_LEFT    = 3'd0;
	localparam logic [2:0] REG_BOUND_TOP     = 3'd1;
	localparam logic [2:0] REG_BOUND_RIGHT   = 3'd2;
	localparam logic [2:0] REG_BOUND_BOTTOM  = 3'd3;
	localparam logic [2:0] REG_EDGE_MODE     = 3'd4;
	localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd5;
	localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd6;

	localparam int PADDR_BITS = 5;

	// Register reset values.
	localparam logic signed [15:0] BOUND_LEFT_RST    = 16'sd0;
	localparam logic signed [15:0] BOUND_TOP_RST     = 16'sd0;
	localparam logic signed [15:0] BOUND_RIGHT_RST   = 16'sd640;
	localparam logic signed [15:0] BOUND_BOTTOM_RST  = 16'sd480;
	localparam logic [1:0]         EDGE_MODE_RST     = MODE_STOP;
	localparam logic [11:0]        SPRITE_WIDTH_RST  = 12'd16;
	localparam logic [11:0]        SPRITE_HEIGHT_RST = 12'd16;

endpackage

`default_nettype wire

// File: hw/rtl/sbm_ifs.sv
// Channel interfaces of the sprite bounds motion step unit: the command
// channel and the result channel. Each carries valid, ready and the payload.
`default_nettype none

interface sbm_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] load_x;
	logic signed [15:0] load_y;
	logic signed [15:0] load_vx;
	logic signed [15:0] load_vy;

	modport source (output valid, kind, load_x, load_y, load_vx, load_vy, input ready);
	modport sink (input valid, kind, load_x, load_y, load_vx, load_vy, output ready);
endinterface

interface sbm_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic               killed;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, killed, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, killed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sprite_bounds_motion_step_unit.sv
// Top level of the sprite bounds motion step unit: APB register file, input
// register, move and edge logic, result register. Uses sbm_pkg and sbm_ifs.

// The unit holds one sprite's position, velocity and pending-kill flag. It
// takes one beat per cycle on cmd while res does not stall: a beat is first
// captured in an input register; when it advances, the move and edge logic
// updates the state and the result beat appears on res. Every beat passes
// through the position and velocity registers. When res is stalled, the
// input register holds one more beat and then cmd.ready drops. Registers sit
// at byte addresses 0, 4, ... 24 in the order bound_left, bound_top,
// bound_right, bound_bottom, edge_mode, sprite_width, sprite_height; the user
// must write them only while no beat is in flight; the block does not enforce
// it. COORD_BITS sets the width of the position and velocity state; results
// show its low 16 bits.
`default_nettype none

module sprite_bounds_motion_step_unit
	import sbm_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [PADDR_BITS-1:0] paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	sbm_cmd_if.sink               cmd,
	sbm_res_if.source             res
);

	localparam int CB_EXT = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int WB     = CB_EXT + 4;

	// Register file.
	logic signed [15:0] bound_left_q, bound_top_q, bound_right_q, bound_bottom_q;
	logic [1:0]         edge_mode_q;
	logic [11:0]        sprite_width_q, sprite_height_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	// Sprite state.
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, speed_x_q, speed_y_q;
	logic                         kill_pending_q;

	// Input register and result control.
	logic               valid_s1;
	logic [1:0]         kind_s1;
	logic signed [15:0] load_x_s1, load_y_s1, load_vx_s1, load_vy_s1;
	logic               res_valid_q, killed_q;
	logic               advance;

	// Next state.
	logic signed [COORD_BITS-1:0] nxt_x, nxt_y, nxt_vx, nxt_vy;
	logic                         nxt_pend, nxt_kill;
	logic signed [WB-1:0]         out_x_w, out_y_w, out_vx_w, out_vy_w;

	function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [WB-1:0] v);
		logic signed [WB-1:0] hi;
		logic signed [WB-1:0] lo;
		hi = {{(WB - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			sat_c = hi[COORD_BITS-1:0];
		end else if (v < lo) begin
			sat_c = lo[COORD_BITS-1:0];
		end else begin
			sat_c = v[COORD_BITS-1:0];
		end
	endfunction

	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_BITS-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_left_q    <= BOUND_LEFT_RST;
			bound_top_q     <= BOUND_TOP_RST;
			bound_right_q   <= BOUND_RIGHT_RST;
			bound_bottom_q  <= BOUND_BOTTOM_RST;
			edge_mode_q     <= EDGE_MODE_RST;
			sprite_width_q  <= SPRITE_WIDTH_RST;
			sprite_height_q <= SPRITE_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BOUND_LEFT:    bound_left_q    <= pwdata[15:0];
				REG_BOUND_TOP:     bound_top_q     <= pwdata[15:0];
				REG_BOUND_RIGHT:   bound_right_q   <= pwdata[15:0];
				REG_BOUND_BOTTOM:  bound_bottom_q  <= pwdata[15:0];
				REG_EDGE_MODE:     edge_mode_q     <= pwdata[1:0];
				REG_SPRITE_WIDTH:  sprite_width_q  <= pwdata[11:0];
				REG_SPRITE_HEIGHT: sprite_height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BOUND_LEFT:    prdata = {16'b0, bound_left_q};
			REG_BOUND_TOP:     prdata = {16'b0, bound_top_q};
			REG_BOUND_RIGHT:   prdata = {16'b0, bound_right_q};
			REG_BOUND_BOTTOM:  prdata = {16'b0, bound_bottom_q};
			REG_EDGE_MODE:     prdata = {30'b0, edge_mode_q};
			REG_SPRITE_WIDTH:  prdata = {20'b0, sprite_width_q};
			REG_SPRITE_HEIGHT: prdata = {20'b0, sprite_height_q};
			default:           prdata = 32'b0;
		endcase
	end

	// The input register moves on when the result register is free or
	// its beat is taken in this cycle.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			kind_s1    <= cmd.kind;
			load_x_s1  <= cmd.load_x;
			load_y_s1  <= cmd.load_y;
			load_vx_s1 <= cmd.load_vx;
			load_vy_s1 <= cmd.load_vy;
		end
	end

	always_comb begin
		logic signed [WB-1:0] nx, ny, vx, vy;
		logic signed [WB-1:0] bl, bt, br, bb, w, h, lim_x, lim_y;
		logic                 move;

		nxt_x    = cur_x_q;
		nxt_y    = cur_y_q;
		nxt_vx   = speed_x_q;
		nxt_vy   = speed_y_q;
		nxt_pend = kill_pending_q;
		nxt_kill = 1'b0;

		bl    = WB'(bound_left_q);
		bt    = WB'(bound_top_q);
		br    = WB'(bound_right_q);
		bb    = WB'(bound_bottom_q);
		w     = WB'($signed({1'b0, sprite_width_q}));
		h     = WB'($signed({1'b0, sprite_height_q}));
		lim_x = br - w;
		lim_y = bb - h;
		vx    = WB'(speed_x_q);
		vy    = WB'(speed_y_q);
		nx    = WB'(cur_x_q) + vx;
		ny    = WB'(cur_y_q) + vy;
		move  = 1'b1;

		case (kind_s1)
			KIND_LOAD: begin
				nxt_x  = sat_c(WB'(load_x_s1));
				nxt_y  = sat_c(WB'(load_y_s1));
				nxt_vx = sat_c(WB'(load_vx_s1));
				nxt_vy = sat_c(WB'(load_vy_s1));
			end
			KIND_KILL: begin
				nxt_pend = 1'b1;
			end
			KIND_TICK: begin
				if (kill_pending_q) begin
					nxt_kill = 1'b1;
				end else begin
					case (edge_mode_q)
						MODE_WRAP: begin
							if (nx + w < bl) begin
								nx = br;
							end else if (nx > br) begin
								nx = bl - w;
							end
							if (ny + h < bt) begin
								ny = bb;
							end else if (ny > bb) begin
								ny = bt - h;
							end
						end
						MODE_BOUNCE: begin
							if (nx < bl) begin
								nx = bl;
								vx = -vx;
							end else if (nx + w > br) begin
								nx = lim_x;
								vx = -vx;
							end
							if (ny < bt) begin
								ny = bt;
								vy = -vy;
							end else if (ny + h > bb) begin
								ny = lim_y;
								vy = -vy;
							end
						end
						MODE_DIE: begin
							if (nx + w < bl || nx > br || ny + h < bt || ny > bb) begin
								nxt_kill = 1'b1;
								move     = 1'b0;
							end
						end
						default: begin
							// Stop: clamp to the edge, and the left (top) edge wins
							// when the area is narrower than the sprite.
							if (nx < bl || nx > lim_x) begin
								nx = (nx < lim_x) ? nx : lim_x;
								nx = (nx > bl) ? nx : bl;
								vx = '0;
								vy = '0;
							end
							if (ny < bt || ny > lim_y) begin
								ny = (ny < lim_y) ? ny : lim_y;
								ny = (ny > bt) ? ny : bt;
								vx = '0;
								vy = '0;
							end
						end
					endcase
					if (move) begin
						nxt_x  = sat_c(nx);
						nxt_y  = sat_c(ny);
						nxt_vx = sat_c(vx);
						nxt_vy = sat_c(vy);
					end
				end
			end
			default: ;
		endcase
	end

	// The state registers change only when a new result is loaded, so they
	// double as the payload of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			speed_x_q      <= '0;
			speed_y_q      <= '0;
			kill_pending_q <= 1'b0;
			killed_q       <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				cur_x_q        <= nxt_x;
				cur_y_q        <= nxt_y;
				speed_x_q      <= nxt_vx;
				speed_y_q      <= nxt_vy;
				kill_pending_q <= nxt_pend;
				killed_q       <= nxt_kill;
				res_valid_q    <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign out_x_w  = WB'(cur_x_q);
	assign out_y_w  = WB'(cur_y_q);
	assign out_vx_w = WB'(speed_x_q);
	assign out_vy_w = WB'(speed_y_q);

	assign res.valid  = res_valid_q;
	assign res.pos_x  = out_x_w[15:0];
	assign res.pos_y  = out_y_w[15:0];
	assign res.vel_x  = out_vx_w[15:0];
	assign res.vel_y  = out_vy_w[15:0];
	assign res.killed = killed_q;

	// A kill request leaves the flag set for good.
	a_kill_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_KILL |=> kill_pending_q)
		else $error("kill beat did not set the pending flag");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		kill_pending_q |=> kill_pending_q)
		else $error("pending kill flag cleared");

	// A tick under a pending kill reports a kill and leaves the sprite alone.
	a_pending_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_TICK && kill_pending_q
		|=> killed_q && $stable(cur_x_q) && $stable(cur_y_q) && $stable(speed_x_q))
		else $error("tick under pending kill moved the sprite or was not reported");

	a_load_no_kill: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_LOAD |=> res_valid_q && !killed_q)
		else $error("load beat reported a kill");

endmodule

`default_nettype wire
